### design/dtsi_pkg.sv
`default_nettype none
package dtsi_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned ValueW = 32;

	// character codes
	localparam logic [ByteW-1:0] CharNul    = 8'h00;
	localparam logic [ByteW-1:0] CharTab    = 8'h09;
	localparam logic [ByteW-1:0] CharSpace  = 8'h20;
	localparam logic [ByteW-1:0] CharMinus  = 8'h2D;
	localparam logic [ByteW-1:0] CharEquals = 8'h3D;
	localparam logic [ByteW-1:0] CharZero   = 8'h30;
	localparam logic [ByteW-1:0] CharNine   = 8'h39;

	// sign tracking codes; the unused code behaves as SignPlus
	localparam logic [1:0] SignNone  = 2'd0;
	localparam logic [1:0] SignMinus = 2'd1;
	localparam logic [1:0] SignPlus  = 2'd2;

	typedef struct packed {
		logic [1:0]        sign;
		logic [ValueW-1:0] acc;
		logic              stopped;
	} scan_state_t;

	typedef struct packed {
		logic                     ok;
		logic signed [ValueW-1:0] value;
	} scan_result_t;

endpackage
`default_nettype wire

### design/dtsi_scan.sv
`default_nettype none
module dtsi_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic [dtsi_pkg::ByteW-1:0] text_byte,
	output dtsi_pkg::scan_result_t         result,
	output dtsi_pkg::scan_state_t          state
);
	import dtsi_pkg::*;

	scan_state_t state_q;
	scan_state_t state_d;

	logic              is_end;
	logic              is_sep;
	logic              is_minus;
	logic              is_digit;
	logic [ValueW-1:0] digit;
	logic [ValueW-1:0] acc_x10;

	assign is_end   = (text_byte == CharNul);
	assign is_sep   = (text_byte == CharTab) || (text_byte == CharSpace)
	                  || (text_byte == CharEquals);
	assign is_minus = (text_byte == CharMinus);
	assign is_digit = (text_byte >= CharZero) && (text_byte <= CharNine);
	assign digit    = {{(ValueW-ByteW){1'b0}}, text_byte - CharZero};
	// x10 as x8 + x2, wrapping at 32 bits
	assign acc_x10  = {state_q.acc[ValueW-4:0], 3'b000} + {state_q.acc[ValueW-2:0], 1'b0};

	always_comb begin
		state_d = state_q;
		priority if (is_end) begin
			state_d = '0;
		end else if (state_q.stopped) begin
			state_d = state_q;
		end else if (is_sep) begin
			if (state_q.sign != SignNone) state_d.stopped = 1'b1;
		end else if (is_minus) begin
			if (state_q.sign == SignNone) state_d.sign = SignMinus;
			else state_d.stopped = 1'b1;
		end else if (!is_digit) begin
			state_d.stopped = 1'b1;
		end else begin
			if (state_q.sign == SignNone) state_d.sign = SignPlus;
			state_d.acc = acc_x10 + digit;
		end
	end

	// end-of-text verdict; minus zero and a lone minus both fail
	always_comb begin
		result = '0;
		if (state_q.sign == SignMinus) begin
			if (state_q.acc != '0) begin
				result.ok    = 1'b1;
				result.value = ValueW'(0) - state_q.acc;
			end
		end else if (state_q.sign != SignNone) begin
			result.ok    = 1'b1;
			result.value = state_q.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule
`default_nettype wire

### design/decimal_text_to_signed_integer.sv
`default_nettype none
// Decimal text to signed integer. Bytes of text arrive one per beat on the
// slave side; the block finds the first signed decimal number in each
// zero-terminated string. Leading tabs, spaces and '=' are skipped, one '-'
// makes the number negative, and the first byte that cannot continue the
// number ends the scan (later bytes up to the terminator are ignored). The
// magnitude wraps modulo 2^32. Only the zero byte yields a beat on the master
// side: tuser is the ok flag and tdata the signed value (zero on failure,
// which covers an empty string, a lone '-' and minus zero). After it the
// scanner is back in its reset state for the next string.
// Rate: one byte per clock while the input does not stall. A byte is held in
// the input register until the scanner takes it; the result beat of a
// terminating byte is written to the output register as the scanner takes
// that byte. The input stalls only when a result is held in the output
// register and the waiting byte is a terminator.
module decimal_text_to_signed_integer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] number_value
	output      logic        m_tuser    // [0] number_ok
);
	import dtsi_pkg::*;

	logic              s1_valid_q;
	logic [ByteW-1:0]  byte_s1;
	logic              advance;
	logic              out_free;
	logic              s1_is_end;

	logic              out_valid_q;
	logic              out_ok_s2;
	logic [ValueW-1:0] out_value_s2;

	scan_result_t      result;
	scan_state_t       state;

	assign s1_is_end = (byte_s1 == CharNul);
	assign out_free  = !out_valid_q || m_tready;
	// a non-terminating byte never needs the output slot
	assign advance   = s1_valid_q && (!s1_is_end || out_free);
	assign s_tready  = !s1_valid_q || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	dtsi_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (byte_s1),
		.result    (result),
		.state     (state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && s1_is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_is_end) begin
			out_ok_s2    <= result.ok;
			out_value_s2 <= result.value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_s2;
	assign m_tdata  = out_value_s2;

	// terminator always leaves the scanner cleared
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_is_end |=> state.sign == SignNone && state.acc == '0
			&& !state.stopped)
		else $error("scanner not cleared after terminator");

	// a failed parse reports zero
	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ok_s2 |-> out_value_s2 == '0)
		else $error("failed parse carries nonzero value");

	// a held byte stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(byte_s1))
		else $error("input register lost a stalled byte");

	// a result is only written into a free output slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_is_end |-> out_free)
		else $error("result register overwritten");

endmodule
`default_nettype wire
